FILE: hdl/crji_pkg.sv
// Shared types, widths and codes for the Catmull-Rom joint interpolator.
// No dependencies; imported by the blend unit and the top level.
package crji_pkg;

  localparam int JOINTS = 7;
  localparam int JW     = 24;
  localparam int GW     = 24;
  localparam int SW     = 11;
  localparam int VW     = 63;
  localparam int QW     = 62;
  localparam int SSW    = 2 * JW + $clog2(JOINTS);

  typedef logic signed [JW-1:0] joint_t;
  typedef logic signed [VW-1:0] val_t;
  typedef logic [GW-1:0]        gap_t;

  localparam val_t             ILIM     = 63'sh2000_0000_0000_0000;
  localparam logic [QW-1:0]    QLIM     = 62'h2000_0000_0000_0000;
  localparam logic signed [63:0] ILIM64 = 64'sh2000_0000_0000_0000;
  localparam val_t             JMAX_V   = 63'sd8388607;
  localparam val_t             JMIN_V   = -63'sd8388608;
  localparam gap_t             GAP_MAX  = '1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_EVAL   = 1'b1;
  localparam logic MODE_CR   = 1'b0;
  localparam logic MODE_LIN  = 1'b1;
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_STEPS = 1'b1;
  localparam logic [SW-1:0] STEPS_RESET = 11'd10;

endpackage

FILE: hdl/crji_if.sv
// Valid/ready channels for load/evaluate items and interpolated points.
// Depends on nothing; payload widths follow the field list.
interface crji_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [23:0] new_j0;
  logic signed [23:0] new_j1;
  logic signed [23:0] new_j2;
  logic signed [23:0] new_j3;
  logic signed [23:0] new_j4;
  logic signed [23:0] new_j5;
  logic signed [23:0] new_j6;
  logic [10:0]       step_index;
  modport source(output valid, op, new_j0, new_j1, new_j2, new_j3, new_j4, new_j5, new_j6,
                 step_index, input ready);
  modport sink(input valid, op, new_j0, new_j1, new_j2, new_j3, new_j4, new_j5, new_j6,
               step_index, output ready);
endinterface

interface crji_out_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] out_j0;
  logic signed [23:0] out_j1;
  logic signed [23:0] out_j2;
  logic signed [23:0] out_j3;
  logic signed [23:0] out_j4;
  logic signed [23:0] out_j5;
  logic signed [23:0] out_j6;
  logic              saturated;
  modport source(output valid, out_j0, out_j1, out_j2, out_j3, out_j4, out_j5, out_j6,
                 saturated, input ready);
  modport sink(input valid, out_j0, out_j1, out_j2, out_j3, out_j4, out_j5, out_j6,
               saturated, output ready);
endinterface

FILE: hdl/crji_blend.sv
// Iterative blend unit: x + round(num*(y-x)/den), saturated at +-2^61.
// Four 32x32 partial products, then, unless the quotient saturates, a one-bit-per-cycle restoring divider.
// Depends on crji_pkg.
module crji_blend #(
  parameter int TW = 37
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  crji_pkg::val_t       x,
  input  crji_pkg::val_t       y,
  input  logic signed [TW-1:0] num,
  input  logic [TW-1:0]        den,
  output logic                 done,
  output crji_pkg::val_t       res
);
  import crji_pkg::*;

  localparam int PW = QW + TW;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_CHK, B_DIV, B_FIN} bst_t;

  bst_t            st;
  logic [VW-1:0]   a_r;
  logic [63:0]     b_r;
  logic [TW-1:0]   den_r;
  val_t            x_r;
  logic            neg_r;
  logic [PW-1:0]   acc;
  logic [1:0]      k;
  logic [TW-1:0]   rem;
  logic [QW-1:0]   low;
  logic [QW-1:0]   q;
  logic [5:0]      cnt;

  logic signed [63:0] d;
  logic [VW-1:0]      dmag;
  logic [TW-1:0]      nmag;
  logic [31:0]        ma;
  logic [31:0]        mb;
  logic [63:0]        prod;
  logic [6:0]         sh;
  logic [PW-1:0]      term;
  logic [TW:0]        t;
  logic               ge;
  logic [QW-1:0]      qc;
  logic signed [63:0] sum;
  val_t               sum_c;

  always_comb begin
    d    = {y[VW-1], y} - {x[VW-1], x};
    dmag = d[63] ? VW'(-d) : d[VW-1:0];
    nmag = num[TW-1] ? TW'(-num) : TW'(num);
    ma   = k[0] ? {1'b0, a_r[VW-1:32]} : a_r[31:0];
    mb   = k[1] ? b_r[63:32] : b_r[31:0];
    prod = 64'(ma) * 64'(mb);
    unique case (k)
      2'd0:    sh = 7'd0;
      2'd3:    sh = 7'd64;
      default: sh = 7'd32;
    endcase
    term = PW'(prod) << sh;
    t    = {rem, low[QW-1]};
    ge   = t >= {1'b0, den_r};
    qc   = (q > QLIM) ? QLIM : q;
    sum  = neg_r ? ({x_r[VW-1], x_r} - 64'(qc)) : ({x_r[VW-1], x_r} + 64'(qc));
    if (sum > ILIM64) begin
      sum_c = ILIM;
    end else if (sum < -ILIM64) begin
      sum_c = -ILIM;
    end else begin
      sum_c = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= B_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        B_IDLE: begin
          if (start) begin
            a_r   <= dmag;
            b_r   <= 64'(nmag);
            den_r <= den;
            x_r   <= x;
            neg_r <= (d[63] != num[TW-1]) && (d != 64'sd0) && (num != '0);
            acc   <= PW'(den >> 1);
            k     <= 2'd0;
            st    <= B_MUL;
          end
        end
        B_MUL: begin
          acc <= acc + term;
          k   <= k + 2'd1;
          if (k == 2'd3) begin
            st <= B_CHK;
          end
        end
        B_CHK: begin
          if (acc[PW-1:QW] >= den_r) begin
            q  <= QLIM;
            st <= B_FIN;
          end else begin
            rem <= acc[PW-1:QW];
            low <= acc[QW-1:0];
            q   <= '0;
            cnt <= '0;
            st  <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= ge ? TW'(t - {1'b0, den_r}) : t[TW-1:0];
          low <= {low[QW-2:0], 1'b0};
          q   <= {q[QW-2:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(QW - 1)) begin
            st <= B_FIN;
          end
        end
        B_FIN: begin
          res  <= sum_c;
          done <= 1'b1;
          st   <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  a_done_from_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(st) == B_FIN)
    else $error("blend done without finish step");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (st == B_IDLE && start) |=> st == B_MUL)
    else $error("blend start not taken");
  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    (st == B_MUL && k == 2'd3) |=> st == B_CHK)
    else $error("multiply phase length wrong");

endmodule

FILE: hdl/catmull_rom_joint_interpolator.sv
// Top level: control window, knot gaps, config registers and sequencer.
// Depends on crji_pkg, crji_if (crji_in_if, crji_out_if) and crji_blend.
//
//   channel   dir  handshake      content
//   item_in   in   valid/ready    op, new_j0..new_j6, step_index
//   result    out  valid/ready    out_j0..out_j6, saturated
//   apb       in   psel/penable   interp_mode @0, steps_per_segment @4
//
// Load item: accept, 7 multiply/accumulate pairs, two 32-step square roots.
// Evaluate item: accept, multiply/accumulate of the knot times, then 42 blends centripetal
// or 7 linear; each blend runs the 62-step divider unless its quotient saturates.
// Reset (rst, synchronous) clears the window, the gaps and the registers.
// A finished point waits in the output register; the next item is taken meanwhile.
module catmull_rom_joint_interpolator #(
  parameter int FRAC_BITS = 20,
  parameter int MAX_STEPS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  crji_in_if.sink     item_in,
  crji_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import crji_pkg::*;

  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int TW = GW + NW + 2;
  localparam int MW = GW + 1;
  localparam int JCW = $clog2(JOINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_MUL, S_LD_ACC, S_SQRT1, S_SQRT2,
    S_EV_MUL, S_EV_ACC, S_BL_ISSUE, S_BL_WAIT, S_DONE
  } state_t;
  typedef enum logic [2:0] {BS_A1, BS_A2, BS_A3, BS_B1, BS_B2, BS_C} bstep_t;

  state_t   state;
  bstep_t   bi;
  logic     mode;
  logic [SW-1:0] sps;
  joint_t   cp [4][JOINTS];
  joint_t   inj [JOINTS];
  gap_t     gap [3];
  logic [NW-1:0] n_r;
  logic [NW-1:0] s_r;
  logic [JCW-1:0] jcnt;
  logic [1:0] mk;
  logic [2*MW-1:0] prod_r;
  logic [SSW-1:0]  sum;
  logic [63:0] rad;
  logic [33:0] srem;
  logic [31:0] sroot;
  logic [4:0]  scnt;
  logic signed [TW-1:0] t1, t2, t3, tt;
  val_t a1, a2, a3, b1, b2;
  joint_t res [JOINTS];
  logic   sat;
  logic   ov;
  joint_t oj [JOINTS];
  logic   osat;

  logic [31:0] n_val, s_val;
  logic signed [JW:0] ldiff;
  logic [MW-1:0] lmag;
  logic [MW-1:0] mul_a, mul_b;
  logic [33:0] sq_r2, sq_trial, sq_rem_nx;
  logic [31:0] sq_root_nx;
  logic        sq_ge;
  logic [31:0] distm;
  gap_t        g_eff [3];
  val_t p0, p1, p2, p3;
  val_t bx, by;
  logic signed [TW-1:0] bnum, bden_s;
  logic [TW-1:0] bden;
  logic  bl_start, bl_done;
  val_t  bl_res;
  logic  last_blend;
  logic  jsat;
  joint_t jclip;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode} : {{(32 - SW){1'b0}}, sps};

  assign item_in.ready = (state == S_IDLE);
  assign result.valid  = ov;
  assign result.out_j0 = oj[0];
  assign result.out_j1 = oj[1];
  assign result.out_j2 = oj[2];
  assign result.out_j3 = oj[3];
  assign result.out_j4 = oj[4];
  assign result.out_j5 = oj[5];
  assign result.out_j6 = oj[6];
  assign result.saturated = osat;

  always_comb begin
    n_val = (sps == '0) ? 32'd1 : ((32'(sps) > MAX_STEPS) ? 32'(MAX_STEPS) : 32'(sps));
    s_val = (32'(item_in.step_index) > n_val) ? n_val : 32'(item_in.step_index);
    ldiff = {inj[0][JW-1], inj[0]} - {cp[3][0][JW-1], cp[3][0]};
    lmag  = ldiff[JW] ? MW'(-ldiff) : MW'(ldiff);
    for (int i = 0; i < 3; i++) begin
      g_eff[i] = (gap[i] == '0) ? gap_t'(1) : gap[i];
    end
    if (state == S_LD_MUL) begin
      mul_a = lmag;
      mul_b = lmag;
    end else begin
      unique case (mk)
        2'd0: begin mul_a = MW'(g_eff[0]); mul_b = MW'(n_r); end
        2'd1: begin mul_a = MW'(g_eff[1]); mul_b = MW'(n_r); end
        2'd2: begin mul_a = MW'(g_eff[2]); mul_b = MW'(n_r); end
        default: begin mul_a = MW'(s_r); mul_b = MW'(g_eff[1]); end
      endcase
    end
    sq_r2      = {srem[31:0], rad[63:62]};
    sq_trial   = {sroot, 2'b01};
    sq_ge      = sq_r2 >= sq_trial;
    sq_rem_nx  = sq_ge ? (sq_r2 - sq_trial) : sq_r2;
    sq_root_nx = {sroot[30:0], sq_ge};
    distm      = (sq_root_nx == '0) ? 32'd1 : sq_root_nx;

    p0 = VW'(cp[0][0]);
    p1 = VW'(cp[1][0]);
    p2 = VW'(cp[2][0]);
    p3 = VW'(cp[3][0]);
    if (mode == MODE_LIN) begin
      bx = p1; by = p2; bnum = TW'(signed'({1'b0, s_r})); bden_s = TW'(signed'({1'b0, n_r}));
    end else begin
      unique case (bi)
        BS_A1: begin bx = p0; by = p1; bnum = tt;      bden_s = t1;      end
        BS_A2: begin bx = p1; by = p2; bnum = tt - t1; bden_s = t2 - t1; end
        BS_A3: begin bx = p2; by = p3; bnum = tt - t2; bden_s = t3 - t2; end
        BS_B1: begin bx = a1; by = a2; bnum = tt;      bden_s = t2;      end
        BS_B2: begin bx = a2; by = a3; bnum = tt - t1; bden_s = t3 - t1; end
        default: begin bx = b1; by = b2; bnum = tt - t1; bden_s = t2 - t1; end
      endcase
    end
    bden       = bden_s;
    bl_start   = (state == S_BL_ISSUE);
    last_blend = (mode == MODE_LIN) || (bi == BS_C);
    if (bl_res > JMAX_V) begin
      jclip = joint_t'(JMAX_V);
      jsat  = 1'b1;
    end else if (bl_res < JMIN_V) begin
      jclip = joint_t'(JMIN_V);
      jsat  = 1'b1;
    end else begin
      jclip = bl_res[JW-1:0];
      jsat  = 1'b0;
    end
  end

  crji_blend #(.TW(TW)) u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (bl_start),
    .x     (bx),
    .y     (by),
    .num   (bnum),
    .den   (bden),
    .done  (bl_done),
    .res   (bl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_CR;
      sps   <= STEPS_RESET;
      ov    <= 1'b0;
      for (int p = 0; p < 4; p++) begin
        for (int i = 0; i < JOINTS; i++) begin
          cp[p][i] <= '0;
        end
      end
      for (int i = 0; i < 3; i++) begin
        gap[i] <= '0;
      end
      jcnt <= '0;
      bi   <= BS_A1;
      mk   <= '0;
      scnt <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_MODE) begin
          mode <= pwdata[0];
        end else begin
          sps <= pwdata[SW-1:0];
        end
      end
      if (ov && result.ready && state != S_DONE) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_in.valid) begin
            inj[0] <= item_in.new_j0;
            inj[1] <= item_in.new_j1;
            inj[2] <= item_in.new_j2;
            inj[3] <= item_in.new_j3;
            inj[4] <= item_in.new_j4;
            inj[5] <= item_in.new_j5;
            inj[6] <= item_in.new_j6;
            n_r    <= NW'(n_val);
            s_r    <= NW'(s_val);
            jcnt   <= '0;
            mk     <= '0;
            sum    <= '0;
            sat    <= 1'b0;
            bi     <= BS_A1;
            state  <= (item_in.op == OP_LOAD) ? S_LD_MUL : S_EV_MUL;
          end
        end
        S_LD_MUL: begin
          prod_r <= mul_a * mul_b;
          for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < JOINTS - 1; i++) begin
              cp[p][i] <= cp[p][i+1];
            end
          end
          for (int p = 0; p < 3; p++) begin
            cp[p][JOINTS-1] <= cp[p+1][0];
          end
          cp[3][JOINTS-1] <= inj[0];
          for (int i = 0; i < JOINTS - 1; i++) begin
            inj[i] <= inj[i+1];
          end
          inj[JOINTS-1] <= inj[0];
          state <= S_LD_ACC;
        end
        S_LD_ACC: begin
          sum <= sum + SSW'(prod_r);
          if (jcnt == JCW'(JOINTS - 1)) begin
            jcnt  <= '0;
            rad   <= 64'(sum + SSW'(prod_r));
            srem  <= '0;
            sroot <= '0;
            scnt  <= '0;
            state <= S_SQRT1;
          end else begin
            jcnt  <= jcnt + JCW'(1);
            state <= S_LD_MUL;
          end
        end
        S_SQRT1, S_SQRT2: begin
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31 && state == S_SQRT1) begin
            rad   <= 64'(distm) << FRAC_BITS;
            srem  <= '0;
            sroot <= '0;
            state <= S_SQRT2;
          end else begin
            rad   <= {rad[61:0], 2'b00};
            srem  <= sq_rem_nx;
            sroot <= sq_root_nx;
            if (scnt == 5'd31) begin
              gap[0] <= gap[1];
              gap[1] <= gap[2];
              gap[2] <= (sq_root_nx > 32'(GAP_MAX)) ? GAP_MAX : sq_root_nx[GW-1:0];
              state  <= S_IDLE;
            end
          end
        end
        S_EV_MUL: begin
          prod_r <= mul_a * mul_b;
          state  <= S_EV_ACC;
        end
        S_EV_ACC: begin
          mk <= mk + 2'd1;
          unique case (mk)
            2'd0: t1 <= $signed(prod_r[TW-1:0]);
            2'd1: t2 <= t1 + $signed(prod_r[TW-1:0]);
            2'd2: t3 <= t2 + $signed(prod_r[TW-1:0]);
            default: tt <= t1 + $signed(prod_r[TW-1:0]);
          endcase
          state <= (mk == 2'd3) ? S_BL_ISSUE : S_EV_MUL;
        end
        S_BL_ISSUE: begin
          state <= S_BL_WAIT;
        end
        S_BL_WAIT: begin
          if (bl_done) begin
            unique case (bi)
              BS_A1: a1 <= bl_res;
              BS_A2: a2 <= bl_res;
              BS_A3: a3 <= bl_res;
              BS_B1: b1 <= bl_res;
              BS_B2: b2 <= bl_res;
              default: ;
            endcase
            if (last_blend) begin
              for (int i = 0; i < JOINTS - 1; i++) begin
                res[i] <= res[i+1];
              end
              res[JOINTS-1] <= jclip;
              sat <= sat | jsat;
              for (int p = 0; p < 4; p++) begin
                for (int i = 0; i < JOINTS - 1; i++) begin
                  cp[p][i] <= cp[p][i+1];
                end
                cp[p][JOINTS-1] <= cp[p][0];
              end
              bi <= BS_A1;
              if (jcnt == JCW'(JOINTS - 1)) begin
                jcnt  <= '0;
                state <= S_DONE;
              end else begin
                jcnt  <= jcnt + JCW'(1);
                state <= S_BL_ISSUE;
              end
            end else begin
              bi    <= bstep_t'(bi + 3'd1);
              state <= S_BL_ISSUE;
            end
          end
        end
        S_DONE: begin
          if (!ov || result.ready) begin
            for (int i = 0; i < JOINTS; i++) begin
              oj[i] <= res[i];
            end
            osat  <= sat;
            ov    <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    bl_done |-> state == S_BL_WAIT)
    else $error("blend result outside wait state");
  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT2 && scnt == 5'd31) |=> gap[2] != '0)
    else $error("loaded knot gap is zero");
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready && item_in.op == OP_LOAD) |=> state == S_LD_MUL)
    else $error("load item not started");
  a_jcnt_range: assert property (@(posedge clk) disable iff (rst)
    jcnt <= JCW'(JOINTS - 1))
    else $error("joint counter out of range");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && ov && !result.ready) |=> state == S_DONE)
    else $error("result overwritten while pending");

endmodule
